// File: rtl/utrb_pkg.sv
package utrb_pkg;

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_HOST_WR  = 2'd0;
  localparam logic [1:0] OP_TX_READY = 2'd1;
  localparam logic [1:0] OP_RX_BYTE  = 2'd2;
  localparam logic [1:0] OP_HOST_RD  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the transaction and read both ring heads
    logic execute;  // update the rings and load the result register
  } utrb_cmd_t;

endpackage

// File: rtl/utrb_ctrl.sv
module utrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output utrb_pkg::utrb_cmd_t cmd
);
  import utrb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   res_free;

  // The result register can take a new transaction when empty or being drained.
  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (res_free) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and the registered result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/utrb_dp.sv
module utrb_dp #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16,
  parameter int TX_CW    = $clog2(TX_DEPTH + 1),
  parameter int RX_CW    = $clog2(RX_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  utrb_pkg::utrb_cmd_t cmd,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_data_byte,
  input  logic                in_framing_error,
  input  logic                in_overrun_error,
  output logic                out_tx_valid,
  output logic [7:0]          out_tx_byte,
  output logic [7:0]          out_read_byte,
  output logic                out_read_framing_flag,
  output logic                out_read_overrun_flag,
  output logic                out_framing_event,
  output logic                out_overrun_event,
  output logic                out_receive_error_event,
  output logic                out_tx_ready_enable,
  output logic [TX_CW-1:0]    out_tx_space_left,
  output logic [RX_CW-1:0]    out_rx_entries,
  output logic                out_refused
);
  import utrb_pkg::*;

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);

  // Ring stores.
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  logic [1:0] rxs_mem [RX_DEPTH];

  // Ring pointers, counts and the transmit enable.
  logic [TX_AW-1:0] tx_wr_ptr_r, tx_wr_ptr_nxt;
  logic [TX_AW-1:0] tx_rd_ptr_r, tx_rd_ptr_nxt;
  logic [TX_CW-1:0] tx_free_r, tx_free_nxt;
  logic             tx_en_r, tx_en_nxt;
  logic [RX_AW-1:0] rx_wr_ptr_r, rx_wr_ptr_nxt;
  logic [RX_AW-1:0] rx_rd_ptr_r, rx_rd_ptr_nxt;
  logic [RX_CW-1:0] rx_fill_r, rx_fill_nxt;

  // Captured transaction and registered ring head reads.
  logic [1:0] op_r;
  logic [7:0] data_r;
  logic       ferr_r;
  logic       oerr_r;
  logic [7:0] tx_head_r;
  logic [7:0] rx_head_r;
  logic [1:0] rxs_head_r;

  // Result of the transaction being executed.
  logic       tx_we;
  logic       rx_we;
  logic       res_tx_valid;
  logic [7:0] res_tx_byte;
  logic [7:0] res_read_byte;
  logic       res_rd_ferr;
  logic       res_rd_oerr;
  logic       res_fev;
  logic       res_oev;
  logic       res_err;
  logic       res_refused;

  // Result registers.
  logic             tx_valid_r;
  logic [7:0]       tx_byte_r;
  logic [7:0]       read_byte_r;
  logic             rd_ferr_r;
  logic             rd_oerr_r;
  logic             fev_r;
  logic             oev_r;
  logic             err_r;
  logic             en_out_r;
  logic [TX_CW-1:0] space_r;
  logic [RX_CW-1:0] entries_r;
  logic             refused_r;

  // Capture the transaction and read both ring heads.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_opcode;
      data_r     <= in_data_byte;
      ferr_r     <= in_framing_error;
      oerr_r     <= in_overrun_error;
      tx_head_r  <= tx_mem[tx_rd_ptr_r];
      rx_head_r  <= rx_mem[rx_rd_ptr_r];
      rxs_head_r <= rxs_mem[rx_rd_ptr_r];
    end
  end

  // Decode the transaction and compute the next ring state.
  always_comb begin
    tx_wr_ptr_nxt = tx_wr_ptr_r;
    tx_rd_ptr_nxt = tx_rd_ptr_r;
    tx_free_nxt   = tx_free_r;
    tx_en_nxt     = tx_en_r;
    rx_wr_ptr_nxt = rx_wr_ptr_r;
    rx_rd_ptr_nxt = rx_rd_ptr_r;
    rx_fill_nxt   = rx_fill_r;
    tx_we         = 1'b0;
    rx_we         = 1'b0;
    res_tx_valid  = 1'b0;
    res_tx_byte   = 8'd0;
    res_read_byte = 8'd0;
    res_rd_ferr   = 1'b0;
    res_rd_oerr   = 1'b0;
    res_fev       = 1'b0;
    res_oev       = 1'b0;
    res_err       = 1'b0;
    res_refused   = 1'b0;
    unique case (op_r)
      OP_HOST_WR: begin
        tx_en_nxt = 1'b1;
        if (tx_free_r == '0) begin
          res_refused = 1'b1;
        end else begin
          tx_we         = 1'b1;
          tx_wr_ptr_nxt = (tx_wr_ptr_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr_r + 1'b1;
          tx_free_nxt   = tx_free_r - 1'b1;
        end
      end
      OP_TX_READY: begin
        if (tx_free_r != TX_CW'(TX_DEPTH)) begin
          res_tx_valid  = 1'b1;
          res_tx_byte   = tx_head_r;
          tx_rd_ptr_nxt = (tx_rd_ptr_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr_r + 1'b1;
          tx_free_nxt   = tx_free_r + 1'b1;
        end else begin
          // Nothing left to send: stop asking for transmitter-ready events.
          tx_en_nxt = 1'b0;
        end
      end
      OP_RX_BYTE: begin
        res_fev = ferr_r;
        res_oev = oerr_r;
        if (ferr_r || oerr_r) begin
          res_err = 1'b1;
        end else if (rx_fill_r == RX_CW'(RX_DEPTH)) begin
          res_refused = 1'b1;
        end else begin
          rx_we         = 1'b1;
          rx_wr_ptr_nxt = (rx_wr_ptr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr_r + 1'b1;
          rx_fill_nxt   = rx_fill_r + 1'b1;
        end
      end
      OP_HOST_RD: begin
        if (rx_fill_r == '0) begin
          res_refused = 1'b1;
        end else begin
          res_read_byte = rx_head_r;
          res_rd_ferr   = rxs_head_r[0];
          res_rd_oerr   = rxs_head_r[1];
          rx_rd_ptr_nxt = (rx_rd_ptr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr_r + 1'b1;
          rx_fill_nxt   = rx_fill_r - 1'b1;
        end
      end
      default: begin
        res_refused = 1'b0;
      end
    endcase
  end

  // Ring store writes.
  always_ff @(posedge clk) begin
    if (cmd.execute && tx_we) begin
      tx_mem[tx_wr_ptr_r] <= data_r;
    end
    if (cmd.execute && rx_we) begin
      rx_mem[rx_wr_ptr_r]  <= data_r;
      rxs_mem[rx_wr_ptr_r] <= {oerr_r, ferr_r};
    end
  end

  // Pointers, counts and enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wr_ptr_r <= '0;
      tx_rd_ptr_r <= '0;
      tx_free_r   <= TX_CW'(TX_DEPTH);
      tx_en_r     <= 1'b0;
      rx_wr_ptr_r <= '0;
      rx_rd_ptr_r <= '0;
      rx_fill_r   <= '0;
    end else if (cmd.execute) begin
      tx_wr_ptr_r <= tx_wr_ptr_nxt;
      tx_rd_ptr_r <= tx_rd_ptr_nxt;
      tx_free_r   <= tx_free_nxt;
      tx_en_r     <= tx_en_nxt;
      rx_wr_ptr_r <= rx_wr_ptr_nxt;
      rx_rd_ptr_r <= rx_rd_ptr_nxt;
      rx_fill_r   <= rx_fill_nxt;
    end
  end

  // Result register, loaded once per transaction.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      tx_valid_r  <= res_tx_valid;
      tx_byte_r   <= res_tx_byte;
      read_byte_r <= res_read_byte;
      rd_ferr_r   <= res_rd_ferr;
      rd_oerr_r   <= res_rd_oerr;
      fev_r       <= res_fev;
      oev_r       <= res_oev;
      err_r       <= res_err;
      en_out_r    <= tx_en_nxt;
      space_r     <= tx_free_nxt;
      entries_r   <= rx_fill_nxt;
      refused_r   <= res_refused;
    end
  end

  assign out_tx_valid            = tx_valid_r;
  assign out_tx_byte             = tx_byte_r;
  assign out_read_byte           = read_byte_r;
  assign out_read_framing_flag   = rd_ferr_r;
  assign out_read_overrun_flag   = rd_oerr_r;
  assign out_framing_event       = fev_r;
  assign out_overrun_event       = oev_r;
  assign out_receive_error_event = err_r;
  assign out_tx_ready_enable     = en_out_r;
  assign out_tx_space_left       = space_r;
  assign out_rx_entries          = entries_r;
  assign out_refused             = refused_r;

endmodule

// File: rtl/uart_tx_rx_ring_buffers_unit.sv
// Channel   Direction  Handshake                Payload
// in_       input      in_valid / in_ready      opcode, data byte, framing and overrun flags
// out_      output     out_valid / out_ready    transmit byte, read byte and flags, events,
//                                               enable, free and filled counts, refused
//
// Each transaction is handled in two steps: capture it and read both ring heads through
// the registered memory read ports, then update the rings and load the result register.
// A new transaction is accepted while the previous result still waits to be taken; its
// execute step waits until the result register is free.
// Reset clears pointers, counts and the transmit enable; ring contents are not cleared.
module uart_tx_rx_ring_buffers_unit #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_opcode,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_framing_error,
  input  logic                               in_overrun_error,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_tx_valid,
  output logic [7:0]                         out_tx_byte,
  output logic [7:0]                         out_read_byte,
  output logic                               out_read_framing_flag,
  output logic                               out_read_overrun_flag,
  output logic                               out_framing_event,
  output logic                               out_overrun_event,
  output logic                               out_receive_error_event,
  output logic                               out_tx_ready_enable,
  output logic [$clog2(TX_DEPTH + 1)-1:0]    out_tx_space_left,
  output logic [$clog2(RX_DEPTH + 1)-1:0]    out_rx_entries,
  output logic                               out_refused
);
  import utrb_pkg::*;

  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);

  utrb_cmd_t cmd;

  // Sequencer for capture and execute.
  utrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Ring stores, pointers and result register.
  utrb_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH),
    .TX_CW    (TX_CW),
    .RX_CW    (RX_CW)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .in_opcode               (in_opcode),
    .in_data_byte            (in_data_byte),
    .in_framing_error        (in_framing_error),
    .in_overrun_error        (in_overrun_error),
    .out_tx_valid            (out_tx_valid),
    .out_tx_byte             (out_tx_byte),
    .out_read_byte           (out_read_byte),
    .out_read_framing_flag   (out_read_framing_flag),
    .out_read_overrun_flag   (out_read_overrun_flag),
    .out_framing_event       (out_framing_event),
    .out_overrun_event       (out_overrun_event),
    .out_receive_error_event (out_receive_error_event),
    .out_tx_ready_enable     (out_tx_ready_enable),
    .out_tx_space_left       (out_tx_space_left),
    .out_rx_entries          (out_rx_entries),
    .out_refused             (out_refused)
  );

  // A handed-over byte is never refused.
  a_txv_not_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tx_valid && out_refused))
    else $error("transmit byte handed over on a refused transaction");

  // Counts stay within the ring depths.
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tx_space_left <= TX_CW'(TX_DEPTH)) &&
                  (out_rx_entries <= RX_CW'(RX_DEPTH)))
    else $error("ring count beyond depth");

  // A discarded receive byte always carries at least one error event.
  a_err_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_receive_error_event |-> (out_framing_event || out_overrun_event))
    else $error("receive error event without cause");

  // An accepted transaction occupies the block for its execute step.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during execute");

endmodule
